// ===== hdl/dstwr_pkg.sv =====
// Shared widths, types and constants for the double-sided ranging time-of-flight block.
`timescale 1ns / 1ps
`default_nettype none
package dstwr_pkg;

    localparam int STAMP_BITS  = 32;
    localparam int FIELD_BITS  = 32;
    localparam int SUM_BITS    = STAMP_BITS + 2;
    localparam int PROD_BITS   = 2 * STAMP_BITS;
    localparam int FLIGHT_BITS = 41;
    localparam int DIST_BITS   = 44;
    localparam int SCALE_BITS  = 20;
    // wide enough to compare the quotient against the flight limits
    localparam int CMP_BITS    = (PROD_BITS > FLIGHT_BITS) ? PROD_BITS : FLIGHT_BITS + 1;

    localparam int S_DATA_BITS = 6 * FIELD_BITS;
    localparam int M_DATA_BITS = ((FLIGHT_BITS + DIST_BITS + 7) / 8) * 8;
    localparam int M_USER_BITS = 2;

    localparam logic [SCALE_BITS-1:0] SCALE_RESET = SCALE_BITS'(307387);

    typedef logic [STAMP_BITS-1:0] stamp_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] mag;
        logic [SUM_BITS-1:0]  den;
        logic                 neg;
        logic                 zero;
    } front_t;

    typedef struct packed {
        logic [PROD_BITS-1:0] quot;
        logic                 neg;
        logic                 zero;
    } quot_t;

    typedef struct packed {
        logic signed [FLIGHT_BITS-1:0] flight;
        logic signed [DIST_BITS-1:0]   distance;
        logic                          sat;
        logic                          zero;
    } result_t;

endpackage
`default_nettype wire

// ===== hdl/dstwr_front.sv =====
// Interval, product and sign/magnitude stages ahead of the divider.
`timescale 1ns / 1ps
`default_nettype none
module dstwr_front
    import dstwr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic [S_DATA_BITS-1:0] in_data,
    output logic                        out_valid,
    output front_t                      out_data
);

    stamp_t poll_tx, resp_rx, final_tx, poll_rx, resp_tx, final_rx;

    // stage 1: wrapping intervals
    logic   v1_reg;
    stamp_t ra_reg, rb_reg, da_reg, db_reg;

    // stage 2: products and interval sum
    logic                 v2_reg;
    logic [PROD_BITS-1:0] pr_reg, pd_reg;
    logic [SUM_BITS-1:0]  sum_reg, sum_next;

    // stage 3: sign and magnitude of the numerator
    logic                 v3_reg;
    front_t               f3_reg, f3_next;
    logic [PROD_BITS:0]   diff_pr, diff_pd;

    always_comb begin
        poll_tx  = STAMP_BITS'(in_data[0*FIELD_BITS +: FIELD_BITS]);
        resp_rx  = STAMP_BITS'(in_data[1*FIELD_BITS +: FIELD_BITS]);
        final_tx = STAMP_BITS'(in_data[2*FIELD_BITS +: FIELD_BITS]);
        poll_rx  = STAMP_BITS'(in_data[3*FIELD_BITS +: FIELD_BITS]);
        resp_tx  = STAMP_BITS'(in_data[4*FIELD_BITS +: FIELD_BITS]);
        final_rx = STAMP_BITS'(in_data[5*FIELD_BITS +: FIELD_BITS]);
    end

    always_comb begin
        sum_next = SUM_BITS'(ra_reg) + SUM_BITS'(rb_reg) + SUM_BITS'(da_reg)
                 + SUM_BITS'(db_reg);
    end

    always_comb begin
        diff_pr = {1'b0, pr_reg} - {1'b0, pd_reg};
        diff_pd = {1'b0, pd_reg} - {1'b0, pr_reg};
        f3_next.neg  = diff_pr[PROD_BITS];
        f3_next.mag  = diff_pr[PROD_BITS] ? diff_pd[PROD_BITS-1:0] : diff_pr[PROD_BITS-1:0];
        f3_next.den  = sum_reg;
        f3_next.zero = (sum_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ra_reg  <= resp_rx - poll_tx;
            rb_reg  <= final_rx - resp_tx;
            da_reg  <= final_tx - resp_rx;
            db_reg  <= resp_tx - poll_rx;
            pr_reg  <= PROD_BITS'(ra_reg) * PROD_BITS'(rb_reg);
            pd_reg  <= PROD_BITS'(da_reg) * PROD_BITS'(db_reg);
            sum_reg <= sum_next;
            f3_reg  <= f3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = f3_reg;

endmodule
`default_nettype wire

// ===== hdl/dstwr_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module dstwr_div
    import dstwr_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   aresetn,
    input  wire logic   en,
    input  wire logic   in_valid,
    input  wire front_t in_data,
    output logic        out_valid,
    output quot_t       out_data
);

    localparam int STEPS = PROD_BITS;
    localparam int RW    = SUM_BITS;

    typedef struct packed {
        logic [RW-1:0]    rem;
        logic [STEPS-1:0] nq;   // numerator bits shift out the top, quotient bits in below
        logic [RW-1:0]    den;
        logic             neg;
        logic             zero;
    } step_t;

    step_t step_reg   [STEPS];
    logic  valid_reg  [STEPS];
    step_t first;

    always_comb begin
        first.rem  = '0;
        first.nq   = in_data.mag;
        first.den  = in_data.den;
        first.neg  = in_data.neg;
        first.zero = in_data.zero;
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        step_t         cur;
        step_t         nxt;
        logic          cur_valid;
        logic [RW:0]   trial;
        logic [RW:0]   rest;
        logic          ge;

        if (k == 0) begin : g_first
            assign cur       = first;
            assign cur_valid = in_valid;
        end else begin : g_next
            assign cur       = step_reg[k-1];
            assign cur_valid = valid_reg[k-1];
        end

        always_comb begin
            trial    = {cur.rem, cur.nq[STEPS-1]};
            rest     = trial - {1'b0, cur.den};
            ge       = (trial >= {1'b0, cur.den});
            nxt      = cur;
            nxt.rem  = ge ? rest[RW-1:0] : trial[RW-1:0];
            nxt.nq   = {cur.nq[STEPS-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= cur_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                step_reg[k] <= nxt;
            end
        end
    end

    assign out_valid     = valid_reg[STEPS-1];
    assign out_data.quot = step_reg[STEPS-1].nq;
    assign out_data.neg  = step_reg[STEPS-1].neg;
    assign out_data.zero = step_reg[STEPS-1].zero;

endmodule
`default_nettype wire

// ===== hdl/dstwr_back.sv =====
// Saturation of the quotient and the scaled distance with its clamp.
`timescale 1ns / 1ps
`default_nettype none
module dstwr_back
    import dstwr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic [SCALE_BITS-1:0] scale,
    input  wire logic                  in_valid,
    input  wire quot_t                 in_data,
    output logic                       out_valid,
    output result_t                    out_data
);

    localparam int LO_BITS   = FLIGHT_BITS / 2;
    localparam int HI_BITS   = FLIGHT_BITS - LO_BITS;
    localparam int PLO_BITS  = LO_BITS + SCALE_BITS;
    localparam int PHI_BITS  = HI_BITS + SCALE_BITS + 1;
    localparam int FULL_BITS = FLIGHT_BITS + SCALE_BITS + 1;
    localparam int WIDE_BITS = FULL_BITS - 16;

    localparam logic [CMP_BITS-1:0] POS_MAX = CMP_BITS'((65'd1 << (FLIGHT_BITS - 1)) - 65'd1);
    localparam logic [CMP_BITS-1:0] NEG_MAG = CMP_BITS'(65'd1 << (FLIGHT_BITS - 1));

    // stage 1: clamp of the flight time
    logic                          v1_reg;
    logic signed [FLIGHT_BITS-1:0] flight1_reg, flight1_next;
    logic                          sat1_reg, sat1_next;
    logic                          zero1_reg;
    logic [CMP_BITS-1:0]           qx;
    logic [FLIGHT_BITS-1:0]        qm;

    // stage 2: split product
    logic                          v2_reg;
    logic signed [FLIGHT_BITS-1:0] flight2_reg;
    logic                          sat2_reg, zero2_reg;
    logic [PLO_BITS-1:0]           plo_reg;
    logic signed [PHI_BITS-1:0]    phi_reg;

    // stage 3: combine, shift, clamp
    logic                          v3_reg;
    result_t                       r3_reg;
    logic signed [FULL_BITS-1:0]   full;
    logic [WIDE_BITS-1:0]          wide;
    logic signed [DIST_BITS-1:0]   dist_next;

    always_comb begin
        qx = CMP_BITS'(in_data.quot);
        if (in_data.neg) begin
            sat1_next    = (qx > NEG_MAG);
            qm           = sat1_next ? NEG_MAG[FLIGHT_BITS-1:0] : qx[FLIGHT_BITS-1:0];
            flight1_next = -$signed(qm);
        end else begin
            sat1_next    = (qx > POS_MAX);
            qm           = sat1_next ? POS_MAX[FLIGHT_BITS-1:0] : qx[FLIGHT_BITS-1:0];
            flight1_next = $signed(qm);
        end
        if (in_data.zero) begin
            sat1_next    = 1'b0;
            flight1_next = '0;
        end
    end

    always_comb begin
        full = ($signed(FULL_BITS'(phi_reg)) <<< LO_BITS) + $signed(FULL_BITS'(plo_reg));
        wide = full[FULL_BITS-1:16];
        // wide result fits when its top bits are a plain sign extension
        if (wide[WIDE_BITS-1:DIST_BITS-1] == '0 || wide[WIDE_BITS-1:DIST_BITS-1] == '1) begin
            dist_next = $signed(wide[DIST_BITS-1:0]);
        end else if (wide[WIDE_BITS-1]) begin
            dist_next = $signed({1'b1, {(DIST_BITS-1){1'b0}}});
        end else begin
            dist_next = $signed({1'b0, {(DIST_BITS-1){1'b1}}});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flight1_reg     <= flight1_next;
            sat1_reg        <= sat1_next;
            zero1_reg       <= in_data.zero;
            flight2_reg     <= flight1_reg;
            sat2_reg        <= sat1_reg;
            zero2_reg       <= zero1_reg;
            plo_reg         <= PLO_BITS'(flight1_reg[LO_BITS-1:0]) * PLO_BITS'(scale);
            phi_reg         <= $signed(flight1_reg[FLIGHT_BITS-1:LO_BITS])
                             * $signed({1'b0, scale});
            r3_reg.flight   <= flight2_reg;
            r3_reg.distance <= dist_next;
            r3_reg.sat      <= sat2_reg;
            r3_reg.zero     <= zero2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_data  = r3_reg;

endmodule
`default_nettype wire

// ===== hdl/dstwr_skid.sv =====
// Two-slot output buffer; the pipeline only halts when both slots are full.
`timescale 1ns / 1ps
`default_nettype none
module dstwr_skid
    import dstwr_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    localparam logic [1:0] CNT_EMPTY = 2'd0;
    localparam logic [1:0] CNT_ONE   = 2'd1;
    localparam logic [1:0] CNT_TWO   = 2'd2;

    logic [1:0] count_reg;
    result_t    slot0_reg, slot1_reg;
    logic       pop;

    assign pop = (count_reg != CNT_EMPTY) && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= CNT_EMPTY;
        end else begin
            case (count_reg)
                CNT_EMPTY: if (push) count_reg <= CNT_ONE;
                CNT_ONE: begin
                    if (push && !pop) count_reg <= CNT_TWO;
                    else if (!push && pop) count_reg <= CNT_EMPTY;
                end
                CNT_TWO: if (pop) count_reg <= CNT_ONE;
                default: count_reg <= CNT_EMPTY;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (count_reg)
            CNT_EMPTY: if (push) slot0_reg <= push_data;
            CNT_ONE: begin
                if (push && pop) slot0_reg <= push_data;
                else if (push) slot1_reg <= push_data;
            end
            CNT_TWO: if (pop) slot0_reg <= slot1_reg;
            default: ;
        endcase
    end

    assign full      = (count_reg == CNT_TWO);
    assign out_valid = (count_reg != CNT_EMPTY);
    assign out_data  = slot0_reg;

endmodule
`default_nettype wire

// ===== hdl/ds_twr_time_of_flight.sv =====
// Top level of the double-sided two-way ranging time-of-flight block.
`timescale 1ns / 1ps
`default_nettype none
// Takes one beat of six 32-bit timestamps per ranging exchange and returns one beat
// with the time of flight in ticks (exact integer quotient, truncated toward zero,
// saturated to 41 bits), the distance in mm from the Q16 scale register, and the
// saturated and zero-divisor flags. A new beat is taken every cycle while s_tready
// is high; each result passes through the 64-stage divider that resolves one
// quotient bit per stage, with three stages ahead of it, three behind it and the
// output buffer. Input is held off only while both output slots hold results.
// Write distance_scale only while no exchange is in flight.
module ds_twr_time_of_flight
    import dstwr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // remote_poll_tx, remote_resp_rx, remote_final_tx,
    // local_poll_rx, local_resp_tx, local_final_rx (32 bits each)
    input  wire logic [S_DATA_BITS-1:0] s_tdata,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // flight_ticks [40:0], distance_mm [84:41], zero fill
    output logic [M_DATA_BITS-1:0]      m_tdata,
    // saturated [0], zero_divisor [1]
    output logic [M_USER_BITS-1:0]      m_tuser,
    input  wire logic                   cfg_we,
    input  wire logic [SCALE_BITS-1:0]  cfg_wdata
);

    logic                  en;
    logic                  full;
    logic [SCALE_BITS-1:0] scale_reg;

    logic    front_valid, quot_valid, res_valid;
    front_t  front_data;
    quot_t   quot_data;
    result_t res_data;
    result_t out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg <= SCALE_RESET;
        end else if (cfg_we) begin
            scale_reg <= cfg_wdata;
        end
    end

    assign en       = !full;
    assign s_tready = en;

    dstwr_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_data   (s_tdata),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    dstwr_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (quot_valid),
        .out_data  (quot_data)
    );

    dstwr_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .scale     (scale_reg),
        .in_valid  (quot_valid),
        .in_data   (quot_data),
        .out_valid (res_valid),
        .out_data  (res_data)
    );

    dstwr_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (en && res_valid),
        .push_data (res_data),
        .full      (full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = M_DATA_BITS'({out_res.distance, out_res.flight});
    assign m_tuser = {out_res.zero, out_res.sat};

    // input only held off behind a waiting result
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no result waiting");

    // zero interval sum gives an all-zero result
    a_zero_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tdata == '0 && !m_tuser[0]))
        else $error("zero divisor result not cleared");

    // a saturated flight time sits at one of the two limits
    a_sat_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |->
            (m_tdata[FLIGHT_BITS-1:0] == {1'b0, {(FLIGHT_BITS-1){1'b1}}} ||
             m_tdata[FLIGHT_BITS-1:0] == {1'b1, {(FLIGHT_BITS-1){1'b0}}}))
        else $error("saturated flight time not at a limit");

endmodule
`default_nettype wire
